>>> design/rbpi_pkg.sv
// shared constants, types and tables for the rigid body pose integrator
package rbpi_pkg;

  localparam int POS_W  = 32;
  localparam int VEL_W  = 32;
  localparam int OUT_W  = 32;
  localparam int Q_W    = 32;
  localparam int DT_W   = 16;
  localparam int C_W    = 48;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W;
  localparam int RAD_W  = 64;
  localparam int RT_W   = 32;
  localparam int DVD_W  = 62;
  localparam int QT_W   = 31;
  localparam int CNT_W  = 4;
  localparam int IDX_W  = 5;
  localparam int PD_W   = VEL_W + DT_W + 1;
  localparam int SUM_W  = ((POS_W > VEL_W + 1) ? POS_W : VEL_W + 1) + 1;
  localparam int SX_W   = (POS_W > OUT_W) ? POS_W : OUT_W;

  localparam logic [DT_W-1:0] DT_RESET = 16'd1092;
  localparam logic signed [Q_W-1:0] Q_ONE = 32'sh4000_0000;

  localparam logic signed [SUM_W-1:0] PMAX =
    {{(SUM_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] PMIN = ~PMAX;

  typedef enum logic {
    REG_TIME_STEP = 1'b0,
    REG_FROZEN    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] w;
    logic [1:0] q;
    logic       neg;
    logic       first;
    logic       last;
    logic [1:0] comp;
  } ham_term_t;

  typedef struct packed {
    logic sqrt_go;
    logic div_go;
  } ds_cmd_t;

  typedef struct packed {
    logic            done;
    logic [RT_W-1:0] result;
  } ds_stat_t;

  // term order of (0,omega) * q, three products per component
  function automatic ham_term_t ham_term(input logic [CNT_W-1:0] k);
    ham_term_t t;
    t = '0;
    unique case (k)
      4'd0:  t = '{w: 2'd0, q: 2'd1, neg: 1'b1, first: 1'b1, last: 1'b0, comp: 2'd0};
      4'd1:  t = '{w: 2'd1, q: 2'd2, neg: 1'b1, first: 1'b0, last: 1'b0, comp: 2'd0};
      4'd2:  t = '{w: 2'd2, q: 2'd3, neg: 1'b1, first: 1'b0, last: 1'b1, comp: 2'd0};
      4'd3:  t = '{w: 2'd0, q: 2'd0, neg: 1'b0, first: 1'b1, last: 1'b0, comp: 2'd1};
      4'd4:  t = '{w: 2'd1, q: 2'd3, neg: 1'b0, first: 1'b0, last: 1'b0, comp: 2'd1};
      4'd5:  t = '{w: 2'd2, q: 2'd2, neg: 1'b1, first: 1'b0, last: 1'b1, comp: 2'd1};
      4'd6:  t = '{w: 2'd1, q: 2'd0, neg: 1'b0, first: 1'b1, last: 1'b0, comp: 2'd2};
      4'd7:  t = '{w: 2'd2, q: 2'd1, neg: 1'b0, first: 1'b0, last: 1'b0, comp: 2'd2};
      4'd8:  t = '{w: 2'd0, q: 2'd3, neg: 1'b1, first: 1'b0, last: 1'b1, comp: 2'd2};
      4'd9:  t = '{w: 2'd2, q: 2'd0, neg: 1'b0, first: 1'b1, last: 1'b0, comp: 2'd3};
      4'd10: t = '{w: 2'd0, q: 2'd2, neg: 1'b0, first: 1'b0, last: 1'b0, comp: 2'd3};
      4'd11: t = '{w: 2'd1, q: 2'd1, neg: 1'b1, first: 1'b0, last: 1'b1, comp: 2'd3};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [POS_W-1:0] p);
    logic signed [SX_W-1:0] x;
    logic signed [OUT_W-1:0] r;
    x = SX_W'(p);
    if (x > SX_W'(32'sh7fff_ffff)) begin
      r = 32'sh7fff_ffff;
    end else if (x < SX_W'(32'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = OUT_W'(x);
    end
    return r;
  endfunction

endpackage

>>> design/rigid_body_pose_integrator.sv
// rigid body pose integrator: euler step of position and quaternion with renormalization
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | lin_vel_xyz, ang_vel_xyz (Q16.16)
//  out     | output    | out_valid/out_stall| pos_xyz (Q16.16), quat_wxyz (Q2.30)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// each item runs through the shared 33x33 multiplier (27 products), the shift normalization and
// the bit-serial root and four divisions (one bit a cycle); a frozen body goes straight to
// the output with its pose unchanged.
// one item at a time; the next item is taken while a result waits on out_stall.
// synchronous reset restores dt 1092, zero position and identity orientation.
module rigid_body_pose_integrator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [rbpi_pkg::VEL_W-1:0]  in_lin_vel_x,
  input  logic signed [rbpi_pkg::VEL_W-1:0]  in_lin_vel_y,
  input  logic signed [rbpi_pkg::VEL_W-1:0]  in_lin_vel_z,
  input  logic signed [rbpi_pkg::VEL_W-1:0]  in_ang_vel_x,
  input  logic signed [rbpi_pkg::VEL_W-1:0]  in_ang_vel_y,
  input  logic signed [rbpi_pkg::VEL_W-1:0]  in_ang_vel_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rbpi_pkg::OUT_W-1:0]  out_pos_x,
  output logic signed [rbpi_pkg::OUT_W-1:0]  out_pos_y,
  output logic signed [rbpi_pkg::OUT_W-1:0]  out_pos_z,
  output logic signed [rbpi_pkg::Q_W-1:0]    out_quat_w,
  output logic signed [rbpi_pkg::Q_W-1:0]    out_quat_x,
  output logic signed [rbpi_pkg::Q_W-1:0]    out_quat_y,
  output logic signed [rbpi_pkg::Q_W-1:0]    out_quat_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [rbpi_pkg::DT_W-1:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_POS_MUL, S_POS_ACC, S_HAM_MUL, S_HAM_ACC, S_INC_MUL, S_INC_ACC,
    S_NORM, S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT, S_DIV_GO, S_DIV, S_OUT
  } state_t;

  state_t                               state_r;
  logic [rbpi_pkg::CNT_W-1:0]           cnt_r;
  logic [rbpi_pkg::DT_W-1:0]            dt_r;
  logic                                 frozen_r;
  logic signed [rbpi_pkg::VEL_W-1:0]    lin_r [3];
  logic signed [rbpi_pkg::VEL_W-1:0]    ang_r [3];
  logic signed [rbpi_pkg::POS_W-1:0]    pos_r [3];
  logic signed [rbpi_pkg::Q_W-1:0]      q_r [4];
  logic signed [rbpi_pkg::C_W-1:0]      c_r [4];
  logic signed [rbpi_pkg::ACC_W-1:0]    acc_r;
  logic signed [rbpi_pkg::PROD_W-1:0]   prod_r;
  logic [rbpi_pkg::RT_W-1:0]            rt_r;
  logic                                 out_valid_r;
  logic signed [rbpi_pkg::OUT_W-1:0]    out_pos_r [3];
  logic signed [rbpi_pkg::Q_W-1:0]      out_quat_r [4];

  rbpi_pkg::ham_term_t                  term;
  logic [1:0]                           cidx;
  logic [1:0]                           qidx;
  logic signed [rbpi_pkg::C_W-1:0]      c_rd;
  logic signed [rbpi_pkg::Q_W-1:0]      q_rd;
  logic signed [rbpi_pkg::MUL_W-1:0]    mul_a;
  logic signed [rbpi_pkg::MUL_W-1:0]    mul_b;
  logic signed [rbpi_pkg::MUL_W-1:0]    dt_op;
  logic signed [rbpi_pkg::PD_W-1:0]     rnd;
  logic signed [rbpi_pkg::SUM_W-1:0]    pos_sum;
  logic signed [rbpi_pkg::POS_W-1:0]    pos_nxt;
  logic signed [rbpi_pkg::ACC_W-1:0]    ham_sum;
  logic signed [rbpi_pkg::ACC_W-1:0]    inc_sum;
  logic signed [rbpi_pkg::C_W-1:0]      c_inc;
  logic signed [rbpi_pkg::ACC_W-1:0]    sq_sum;
  logic                                 all_zero;
  logic                                 any_big;
  logic                                 all_small;
  logic [rbpi_pkg::QT_W-1:0]            c_mag;
  logic [rbpi_pkg::DVD_W-1:0]           dvd;
  logic signed [rbpi_pkg::Q_W-1:0]      q_div;
  logic                                 out_load;
  rbpi_pkg::ds_cmd_t                    ds_cmd;
  rbpi_pkg::ds_stat_t                   ds_stat;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    term = rbpi_pkg::ham_term(cnt_r);
    if (state_r == S_INC_MUL || state_r == S_INC_ACC) begin
      cidx = cnt_r[2:1];
    end else begin
      cidx = cnt_r[1:0];
    end
    qidx  = (state_r == S_HAM_MUL) ? term.q : cnt_r[2:1];
    c_rd  = c_r[cidx];
    q_rd  = q_r[qidx];
    dt_op = $signed(rbpi_pkg::MUL_W'(dt_r));

    unique case (state_r)
      S_POS_MUL: begin
        mul_a = rbpi_pkg::MUL_W'(lin_r[cnt_r[1:0]]);
        mul_b = dt_op;
      end
      S_HAM_MUL: begin
        mul_a = rbpi_pkg::MUL_W'(ang_r[term.w]);
        mul_b = rbpi_pkg::MUL_W'(q_rd);
      end
      S_INC_MUL: begin
        if (!cnt_r[0]) begin
          mul_a = rbpi_pkg::MUL_W'($signed(c_rd[rbpi_pkg::C_W-1:24]));
        end else begin
          mul_a = $signed(rbpi_pkg::MUL_W'(c_rd[23:0]));
        end
        mul_b = dt_op;
      end
      S_SQ_MUL: begin
        mul_a = rbpi_pkg::MUL_W'($signed(c_rd[31:0]));
        mul_b = rbpi_pkg::MUL_W'($signed(c_rd[31:0]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // position: round half up, then saturate
  always_comb begin
    rnd     = $signed(prod_r[rbpi_pkg::PD_W-1:0]) + rbpi_pkg::PD_W'(32'sd32768);
    pos_sum = rbpi_pkg::SUM_W'(pos_r[cnt_r[1:0]])
            + rbpi_pkg::SUM_W'($signed(rnd[rbpi_pkg::PD_W-1:16]));
    if (pos_sum > rbpi_pkg::PMAX) begin
      pos_nxt = rbpi_pkg::PMAX[rbpi_pkg::POS_W-1:0];
    end else if (pos_sum < rbpi_pkg::PMIN) begin
      pos_nxt = rbpi_pkg::PMIN[rbpi_pkg::POS_W-1:0];
    end else begin
      pos_nxt = pos_sum[rbpi_pkg::POS_W-1:0];
    end
  end

  always_comb begin
    ham_sum = (term.first ? '0 : acc_r) + (term.neg ? -prod_r : prod_r);
    inc_sum = acc_r + prod_r;
    c_inc   = rbpi_pkg::C_W'(q_rd) + $signed(inc_sum[rbpi_pkg::C_W+16:17]);
    sq_sum  = ((cnt_r == '0) ? '0 : acc_r) + prod_r;
  end

  always_comb begin
    all_zero  = 1'b1;
    any_big   = 1'b0;
    all_small = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (c_r[i] != '0) all_zero = 1'b0;
      if (c_r[i] > 48'sh0000_7fff_ffff || c_r[i] < -48'sh0000_7fff_ffff) any_big = 1'b1;
      if (!(c_r[i] < 48'sh0000_4000_0000 && c_r[i] > -48'sh0000_4000_0000)) all_small = 1'b0;
    end
  end

  always_comb begin
    if (c_rd[rbpi_pkg::C_W-1]) begin
      c_mag = rbpi_pkg::QT_W'(-c_rd[31:0]);
    end else begin
      c_mag = c_rd[rbpi_pkg::QT_W-1:0];
    end
    dvd = {c_mag, 30'b0} + rbpi_pkg::DVD_W'(rt_r >> 1);
    q_div = c_rd[rbpi_pkg::C_W-1] ? -$signed(ds_stat.result) : $signed(ds_stat.result);
    ds_cmd.sqrt_go = (state_r == S_SQRT_GO);
    ds_cmd.div_go  = (state_r == S_DIV_GO);
  end

  rbpi_root_div u_root_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (ds_cmd),
    .rad  (acc_r[rbpi_pkg::RAD_W-1:0]),
    .dvd  (dvd),
    .dvs  (rt_r),
    .stat (ds_stat)
  );

  always_ff @(posedge clk) begin
    prod_r <= rbpi_pkg::PROD_W'(mul_a) * rbpi_pkg::PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dt_r        <= rbpi_pkg::DT_RESET;
      frozen_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) pos_r[i] <= '0;
      q_r[0] <= rbpi_pkg::Q_ONE;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (rbpi_pkg::cfg_reg_t'(cfg_index))
          rbpi_pkg::REG_TIME_STEP: dt_r     <= cfg_data;
          rbpi_pkg::REG_FROZEN:    frozen_r <= cfg_data[0];
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            lin_r[0] <= in_lin_vel_x;
            lin_r[1] <= in_lin_vel_y;
            lin_r[2] <= in_lin_vel_z;
            ang_r[0] <= in_ang_vel_x;
            ang_r[1] <= in_ang_vel_y;
            ang_r[2] <= in_ang_vel_z;
            cnt_r    <= '0;
            state_r  <= frozen_r ? S_OUT : S_POS_MUL;
          end
        end
        S_POS_MUL: state_r <= S_POS_ACC;
        S_POS_ACC: begin
          pos_r[cnt_r[1:0]] <= pos_nxt;
          if (cnt_r == 4'd2) begin
            cnt_r   <= '0;
            state_r <= S_HAM_MUL;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_POS_MUL;
          end
        end
        S_HAM_MUL: state_r <= S_HAM_ACC;
        S_HAM_ACC: begin
          acc_r <= ham_sum;
          if (term.last) begin
            c_r[term.comp] <= ham_sum[rbpi_pkg::C_W+15:16];
          end
          if (cnt_r == 4'd11) begin
            cnt_r   <= '0;
            state_r <= S_INC_MUL;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_HAM_MUL;
          end
        end
        S_INC_MUL: state_r <= S_INC_ACC;
        S_INC_ACC: begin
          if (!cnt_r[0]) begin
            acc_r <= prod_r <<< 24;
          end else begin
            c_r[cnt_r[2:1]] <= c_inc;
          end
          if (cnt_r == 4'd7) begin
            cnt_r   <= '0;
            state_r <= S_NORM;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_INC_MUL;
          end
        end
        S_NORM: begin
          priority if (all_zero) begin
            q_r[0]  <= rbpi_pkg::Q_ONE;
            q_r[1]  <= '0;
            q_r[2]  <= '0;
            q_r[3]  <= '0;
            state_r <= S_OUT;
          end else if (any_big) begin
            for (int i = 0; i < 4; i++) c_r[i] <= c_r[i] >>> 1;
          end else if (all_small) begin
            for (int i = 0; i < 4; i++) c_r[i] <= c_r[i] <<< 1;
          end else begin
            cnt_r   <= '0;
            state_r <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state_r <= S_SQ_ACC;
        S_SQ_ACC: begin
          acc_r <= sq_sum;
          if (cnt_r == 4'd3) begin
            state_r <= S_SQRT_GO;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_SQ_MUL;
          end
        end
        S_SQRT_GO: state_r <= S_SQRT;
        S_SQRT: begin
          if (ds_stat.done) begin
            rt_r    <= ds_stat.result;
            cnt_r   <= '0;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV;
        S_DIV: begin
          if (ds_stat.done) begin
            q_r[cnt_r[1:0]] <= q_div;
            if (cnt_r == 4'd3) begin
              state_r <= S_OUT;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            for (int i = 0; i < 3; i++) out_pos_r[i] <= rbpi_pkg::sat_out(pos_r[i]);
            for (int i = 0; i < 4; i++) out_quat_r[i] <= q_r[i];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_pos_x  = out_pos_r[0];
  assign out_pos_y  = out_pos_r[1];
  assign out_pos_z  = out_pos_r[2];
  assign out_quat_w = out_quat_r[0];
  assign out_quat_x = out_quat_r[1];
  assign out_quat_y = out_quat_r[2];
  assign out_quat_z = out_quat_r[3];

endmodule

>>> design/rbpi_root_div.sv
// iterative integer square root and restoring divider sharing one subtractor
module rbpi_root_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rbpi_pkg::ds_cmd_t                  cmd,
  input  logic [rbpi_pkg::RAD_W-1:0]         rad,
  input  logic [rbpi_pkg::DVD_W-1:0]         dvd,
  input  logic [rbpi_pkg::RT_W-1:0]          dvs,
  output rbpi_pkg::ds_stat_t                 stat
);

  typedef enum logic [1:0] {U_IDLE, U_SQRT, U_DIV} ustate_t;

  ustate_t                        state_r;
  logic [rbpi_pkg::IDX_W-1:0]     idx_r;
  logic [rbpi_pkg::RAD_W-1:0]     n_r;
  logic [rbpi_pkg::RAD_W-1:0]     res_r;
  logic [rbpi_pkg::RT_W-1:0]      rem_r;
  logic [rbpi_pkg::QT_W-1:0]      dvd_r;
  logic [rbpi_pkg::QT_W-1:0]      quot_r;
  logic [rbpi_pkg::RT_W-1:0]      dvs_r;
  logic                           done_r;
  logic [rbpi_pkg::RT_W-1:0]      result_r;

  logic [rbpi_pkg::RAD_W-1:0]     bitv;
  logic [rbpi_pkg::RT_W:0]        t;
  logic [rbpi_pkg::RAD_W-1:0]     opa;
  logic [rbpi_pkg::RAD_W-1:0]     opb;
  logic [rbpi_pkg::RAD_W:0]       diff;
  logic                           ge;
  logic [rbpi_pkg::RAD_W-1:0]     res_nxt;
  logic [rbpi_pkg::QT_W-1:0]      quot_nxt;
  logic                           last_step;

  always_comb begin
    bitv = rbpi_pkg::RAD_W'(1) << {idx_r, 1'b0};
    t    = {rem_r, dvd_r[rbpi_pkg::QT_W-1]};
    if (state_r == U_DIV) begin
      opa = rbpi_pkg::RAD_W'(t);
      opb = rbpi_pkg::RAD_W'(dvs_r);
    end else begin
      opa = n_r;
      opb = res_r + bitv;
    end
    diff      = {1'b0, opa} - {1'b0, opb};
    ge        = ~diff[rbpi_pkg::RAD_W];
    res_nxt   = ge ? ((res_r >> 1) + bitv) : (res_r >> 1);
    quot_nxt  = {quot_r[rbpi_pkg::QT_W-2:0], ge};
    last_step = (state_r != U_IDLE) && (idx_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= last_step;
      unique case (state_r)
        U_IDLE: begin
          if (cmd.sqrt_go) begin
            n_r     <= rad;
            res_r   <= '0;
            idx_r   <= rbpi_pkg::IDX_W'(rbpi_pkg::RT_W - 1);
            state_r <= U_SQRT;
          end else if (cmd.div_go) begin
            rem_r   <= rbpi_pkg::RT_W'(dvd[rbpi_pkg::DVD_W-1:rbpi_pkg::QT_W]);
            dvd_r   <= dvd[rbpi_pkg::QT_W-1:0];
            quot_r  <= '0;
            dvs_r   <= dvs;
            idx_r   <= rbpi_pkg::IDX_W'(rbpi_pkg::QT_W - 1);
            state_r <= U_DIV;
          end
        end
        U_SQRT: begin
          if (ge) begin
            n_r <= diff[rbpi_pkg::RAD_W-1:0];
          end
          res_r <= res_nxt;
          idx_r <= idx_r - 1'b1;
          if (idx_r == '0) begin
            result_r <= res_nxt[rbpi_pkg::RT_W-1:0];
            state_r  <= U_IDLE;
          end
        end
        U_DIV: begin
          rem_r  <= ge ? diff[rbpi_pkg::RT_W-1:0] : t[rbpi_pkg::RT_W-1:0];
          dvd_r  <= {dvd_r[rbpi_pkg::QT_W-2:0], 1'b0};
          quot_r <= quot_nxt;
          idx_r  <= idx_r - 1'b1;
          if (idx_r == '0) begin
            result_r <= rbpi_pkg::RT_W'(quot_nxt);
            state_r  <= U_IDLE;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign stat.done   = done_r;
  assign stat.result = result_r;

endmodule

>>> design/rbpi_chk.sv
// port-level checks for the rigid body pose integrator, bound to the top level
module rbpi_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [rbpi_pkg::Q_W-1:0]    out_quat_w,
  input logic signed [rbpi_pkg::Q_W-1:0]    out_quat_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("item dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking an item");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_w <= 32'sh4000_0000) && (out_quat_w >= -32'sh4000_0000)
               && (out_quat_x <= 32'sh4000_0000) && (out_quat_x >= -32'sh4000_0000))
    else $error("quaternion component out of unit range");

endmodule

bind rigid_body_pose_integrator rbpi_chk u_rbpi_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_quat_w(out_quat_w),
  .out_quat_x(out_quat_x)
);

>>> dv/tb_top.sv
// testbench for the rigid body pose integrator: directed table plus random steps checked against a predictor
`timescale 1ns / 1ps

module tb_top;

  typedef logic [6:0][31:0] pose_t;
  typedef logic [5:0][31:0] vel_t;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t kind;
    vel_t      vel;
    bit        lit;
    pose_t     want;
    rbpi_pkg::cfg_reg_t reg_id;
    logic [15:0] data;
  } row_t;

  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_WAIT   = 300;
  localparam logic [31:0] V_MAX = 32'h7fff_ffff;
  localparam logic [31:0] V_MIN = 32'h8000_0000;
  localparam logic [31:0] V_ONE = 32'h0001_0000;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [31:0] in_lin_vel_x, in_lin_vel_y, in_lin_vel_z;
  logic signed [31:0] in_ang_vel_x, in_ang_vel_y, in_ang_vel_z;
  logic out_valid, out_stall;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;

  rigid_body_pose_integrator DUT (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // predictor state
  longint pos_st[3];
  longint ori_st[4];
  logic [15:0] dt_r;
  bit frozen_r;

  pose_t pose_due[$];
  int fails = 0;
  bit quiet;
  int idle_cnt = 0;
  string fname[7] = '{"pos_x", "pos_y", "pos_z", "quat_w", "quat_x", "quat_y", "quat_z"};

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint magn(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic pose_t advance_pose(vel_t v);
    longint dt, w[3], s[4], c[4], d, m, qv, pmax, pmin;
    longint unsigned n, r, a;
    pose_t p;
    if (!frozen_r) begin
      dt = longint'(dt_r);
      pmax = 64'sd2147483647;
      pmin = -64'sd2147483648;
      for (int i = 0; i < 3; i++) begin
        d = (longint'($signed(v[i])) * dt + 64'sd32768) >>> 16;
        pos_st[i] = pos_st[i] + d;
        if (pos_st[i] > pmax) pos_st[i] = pmax;
        if (pos_st[i] < pmin) pos_st[i] = pmin;
      end
      for (int i = 0; i < 3; i++) w[i] = longint'($signed(v[3 + i]));
      s[0] = -(w[0] * ori_st[1] + w[1] * ori_st[2] + w[2] * ori_st[3]);
      s[1] = w[0] * ori_st[0] + w[1] * ori_st[3] - w[2] * ori_st[2];
      s[2] = w[1] * ori_st[0] + w[2] * ori_st[1] - w[0] * ori_st[3];
      s[3] = w[2] * ori_st[0] + w[0] * ori_st[2] - w[1] * ori_st[1];
      for (int i = 0; i < 4; i++) c[i] = ori_st[i] + (((s[i] >>> 16) * dt) >>> 17);
      m = 0;
      for (int i = 0; i < 4; i++) if (magn(c[i]) > m) m = magn(c[i]);
      if (m == 0) begin
        ori_st[0] = 64'sd1 << 30;
        for (int i = 1; i < 4; i++) ori_st[i] = 0;
      end else begin
        while (m >= (64'sd1 << 31)) begin
          m = 0;
          for (int i = 0; i < 4; i++) begin
            c[i] = c[i] >>> 1;
            if (magn(c[i]) > m) m = magn(c[i]);
          end
        end
        while (m < (64'sd1 << 30)) begin
          for (int i = 0; i < 4; i++) c[i] *= 2;
          m *= 2;
        end
        n = 0;
        for (int i = 0; i < 4; i++) n += longint'(c[i] * c[i]);
        r = root64(n);
        for (int i = 0; i < 4; i++) begin
          a = magn(c[i]);
          qv = longint'(((a << 30) + (r >> 1)) / r);
          ori_st[i] = c[i] < 0 ? -qv : qv;
        end
      end
    end
    for (int i = 0; i < 3; i++) p[i] = pos_st[i][31:0];
    for (int i = 0; i < 4; i++) p[3 + i] = ori_st[i][31:0];
    return p;
  endfunction

  task automatic send_item(vel_t v, bit lit, pose_t want, bit gaps);
    pose_t p;
    @(negedge clk);
    in_valid <= 1'b1;
    {in_ang_vel_z, in_ang_vel_y, in_ang_vel_x, in_lin_vel_z, in_lin_vel_y, in_lin_vel_x} <= v;
    do @(posedge clk); while (in_stall);
    p = advance_pose(v);
    pose_due.push_back(lit ? want : p);
    if (gaps && $urandom_range(3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  task automatic write_reg(rbpi_pkg::cfg_reg_t id, logic [15:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pose_due.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= id;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (id == rbpi_pkg::REG_TIME_STEP) dt_r = val;
    else frozen_r = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return 32'($urandom_range(0, 16 * 65536)) - 32'(8 * 65536);
    if (sel < 9) return $urandom;
    case ($urandom_range(3))
      0: return V_MAX;
      1: return V_MIN;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic vel_t rand_vel();
    vel_t v;
    for (int i = 0; i < 6; i++) v[i] = rand_word();
    return v;
  endfunction

  function automatic row_t item_row(vel_t v);
    row_t r;
    r.kind = ROW_ITEM;
    r.vel = v;
    r.lit = 1'b0;
    r.want = '0;
    r.reg_id = rbpi_pkg::REG_TIME_STEP;
    r.data = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(rbpi_pkg::cfg_reg_t id, logic [15:0] val);
    row_t r;
    r = item_row('0);
    r.kind = ROW_CFG;
    r.reg_id = id;
    r.data = val;
    return r;
  endfunction

  // result check
  always @(posedge clk) begin
    pose_t got, exp_p;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_quat_z, out_quat_y, out_quat_x, out_quat_w, out_pos_z, out_pos_y, out_pos_x};
      if (pose_due.size() == 0) begin
        $display("%0t: unexpected item, actual %p", $time, got);
        fails++;
      end else begin
        exp_p = pose_due.pop_front();
        for (int i = 0; i < 7; i++)
          if (got[i] !== exp_p[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, fname[i],
                     $signed(exp_p[i]), $signed(got[i]));
            fails++;
          end
      end
    end
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    vel_t v;
    pose_t ident;
    int phase_dt[5];
    phase_dt = '{1092, 0, 65535, 300, 5000};
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_lin_vel_x, in_lin_vel_y, in_lin_vel_z} = '0;
    {in_ang_vel_x, in_ang_vel_y, in_ang_vel_z} = '0;
    cfg_valid = 1'b0;
    cfg_index = rbpi_pkg::REG_TIME_STEP;
    cfg_data = '0;
    dt_r = rbpi_pkg::DT_RESET;
    frozen_r = 1'b0;
    for (int i = 0; i < 3; i++) pos_st[i] = 0;
    ori_st[0] = 64'sd1 << 30;
    for (int i = 1; i < 4; i++) ori_st[i] = 0;
    ident = '0;
    ident[3] = rbpi_pkg::Q_ONE;

    // directed table
    r = item_row('0);
    r.lit = 1'b1;
    r.want = ident;
    rows.push_back(r);
    r = item_row({32'h0, 32'h0, 32'h0, V_ONE, V_ONE, V_ONE});
    r.lit = 1'b1;
    r.want = ident;
    r.want[0] = 32'd1092;
    r.want[1] = 32'd1092;
    r.want[2] = 32'd1092;
    rows.push_back(r);
    rows.push_back(item_row({32'h0, 32'h0, V_ONE, 32'h0, 32'h0, 32'h0}));
    rows.push_back(item_row({32'h0, V_ONE, 32'h0, 32'h0, 32'h0, 32'h0}));
    rows.push_back(item_row({V_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}));
    rows.push_back(item_row({-V_ONE, 32'h3_0000, -32'h2_8000, -V_ONE, V_ONE, 32'h8000}));
    rows.push_back(item_row({6{V_MAX}}));
    rows.push_back(item_row({6{V_MIN}}));
    rows.push_back(cfg_row(rbpi_pkg::REG_TIME_STEP, 16'hffff));
    repeat (3) rows.push_back(item_row({{3{32'h0}}, {3{V_MAX}}}));
    repeat (4) rows.push_back(item_row({{3{32'h0}}, {3{V_MIN}}}));
    rows.push_back(item_row({V_MIN, V_MAX, V_MIN, 32'h0, 32'h0, 32'h0}));
    rows.push_back(cfg_row(rbpi_pkg::REG_FROZEN, 16'd1));
    rows.push_back(item_row({V_MAX, V_MIN, V_ONE, V_MAX, V_MIN, V_ONE}));
    rows.push_back(item_row({6{32'h1234_5678}}));
    rows.push_back(cfg_row(rbpi_pkg::REG_TIME_STEP, 16'd0));
    rows.push_back(cfg_row(rbpi_pkg::REG_FROZEN, 16'd0));
    rows.push_back(item_row({6{V_MAX}}));
    rows.push_back(cfg_row(rbpi_pkg::REG_TIME_STEP, rbpi_pkg::DT_RESET));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].reg_id, rows[i].data);
      else send_item(rows[i].vel, rows[i].lit, rows[i].want, 1'b1);
    end

    // random phases over several step sizes, one frozen
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(rbpi_pkg::REG_TIME_STEP,
                16'(phase_dt[ph] == 300 ? $urandom_range(0, 65535) : phase_dt[ph]));
      write_reg(rbpi_pkg::REG_FROZEN, ph == 3 ? 16'd1 : 16'd0);
      if (ph == 4) quiet = 1'b1;
      for (int k = 0; k < 100; k++) begin
        v = rand_vel();
        send_item(v, 1'b0, '0, !quiet);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pose_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
